/* hw/rtl/crf_pkg.sv */
// ----------------------------------------------------------------------------
// crf_pkg: cassette record framer shared definitions
// Field widths, framing constants, sequencer step codes and the command
// word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package crf_pkg;

    localparam int OPCODE_W  = 1;
    localparam int LEN_W     = 18;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int REP_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int FILL_W    = 7;

    localparam logic [OPCODE_W-1:0] OP_BEGIN = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_DATA  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR    = 2'd0,
        KIND_MARK    = 2'd1,
        KIND_SILENCE = 2'd2
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE   = 2'd2;

    localparam logic [REP_W-1:0] RST_SHORT_GAP = 14'd151;
    localparam logic [REP_W-1:0] RST_LONG_GAP  = 14'd12080;
    localparam logic [REP_W-1:0] RST_SILENCE   = 14'd60;

    localparam int RECORD_BYTES = 128;
    localparam logic [FILL_W-1:0] FILL_LAST = 7'd127;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] CTRL_EOF  = 8'hFE;
    localparam logic [BYTE_W-1:0] CTRL_FULL = 8'hFC;
    localparam logic [BYTE_W-1:0] CTRL_PART = 8'hFA;
    localparam logic [BYTE_W-1:0] SUM_EOF   = 8'hA9;
    localparam logic [BYTE_W-1:0] SEED_FULL = 8'hA7;
    localparam logic [BYTE_W-1:0] SEED_PART = 8'hA5;
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    localparam logic [REP_W-1:0] REP_ONE    = 14'd1;
    localparam logic [REP_W-1:0] REP_SYNC   = 14'd2;
    localparam logic [REP_W-1:0] REP_RECORD = 14'(RECORD_BYTES);

    // Output steps of one command, in emission order
    localparam int STEP_COUNT = 11;
    localparam int STEP_W     = 4;
    localparam logic [STEP_W-1:0] STEP_LEAD   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DATA   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PAD    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LEN    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CKSUM  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_GAP    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SYNC   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CTRL   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_ZERO   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_EOFSUM = 4'd9;
    localparam logic [STEP_W-1:0] STEP_SIL    = 4'd10;

    typedef logic [STEP_COUNT-1:0] t_step_mask;

    typedef struct packed {
        t_step_mask        mask;
        logic [BYTE_W-1:0] data;
        logic [FILL_W-1:0] pad;
        logic [BYTE_W-1:0] len_byte;
        logic [BYTE_W-1:0] cksum;
        logic [BYTE_W-1:0] ctrl;
    } t_cmd;

    typedef struct packed {
        logic [REP_W-1:0] short_gap;
        logic [REP_W-1:0] long_gap;
        logic [REP_W-1:0] silence;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic valid;
    } t_fifo_stat;

    // 8-bit sum with end-around carry
    function automatic logic [BYTE_W-1:0] add_carry(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s[BYTE_W-1:0] & BYTE_MASK) + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
    endfunction

endpackage

/* hw/rtl/crf_if.sv */
// ----------------------------------------------------------------------------
// crf_if: cassette record framer channel interfaces
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface crf_in_if;
    logic                          valid;
    logic                          ready;
    logic [crf_pkg::OPCODE_W-1:0]  opcode;
    logic [crf_pkg::LEN_W-1:0]     file_length;
    logic [crf_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, opcode, file_length, data_byte, input ready);
    modport sink   (input valid, opcode, file_length, data_byte, output ready);
endinterface

interface crf_out_if;
    logic                          valid;
    logic                          ready;
    logic [crf_pkg::KIND_W-1:0]    kind;
    logic [crf_pkg::BYTE_W-1:0]    char_byte;
    logic [crf_pkg::REP_W-1:0]     repeat_res;
    logic                          last;

    modport source (output valid, kind, char_byte, repeat_res, last, input ready);
    modport sink   (input valid, kind, char_byte, repeat_res, last, output ready);
endinterface

interface crf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [crf_pkg::CFG_IDX_W-1:0] index;
    logic [crf_pkg::REP_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/crf_front.sv */
// ----------------------------------------------------------------------------
// crf_front: input word classifier and file state
// Tracks the open file, record fill and checksum, holds the gap registers,
// and turns accepted words that cause output into sequencer commands.
// ----------------------------------------------------------------------------
module crf_front #(
    parameter int MAX_FILE_BYTES = 131072
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    crf_in_if.sink               i_in_chan,
    crf_cfg_if.sink              i_cfg_chan,
    input  crf_pkg::t_fifo_stat  i_fifo_stat,
    output logic                 o_push,
    output crf_pkg::t_cmd        o_cmd,
    output crf_pkg::t_cfg        o_cfg
);

    localparam int BR_W = $clog2(MAX_FILE_BYTES + 1);

    logic                        r_open;
    logic [BR_W-1:0]             r_rem;
    logic [crf_pkg::FILL_W-1:0]  r_fill;
    logic [crf_pkg::BYTE_W-1:0]  r_sum;
    crf_pkg::t_cfg               r_cfg;

    logic                        n_open;
    logic [BR_W-1:0]             n_rem;
    logic [crf_pkg::FILL_W-1:0]  n_fill;
    logic [crf_pkg::BYTE_W-1:0]  n_sum;

    logic                        accept;
    logic [BR_W-1:0]             len_sat;
    logic [BR_W-1:0]             rem1;
    logic [crf_pkg::BYTE_W-1:0]  fill1;
    logic [crf_pkg::BYTE_W-1:0]  sum1;
    logic [crf_pkg::BYTE_W-1:0]  sum2;
    logic [crf_pkg::FILL_W-1:0]  pad;
    logic                        do_eof;
    logic                        do_open;
    logic                        open_full;
    crf_pkg::t_cmd               cmd;

    assign accept           = i_in_chan.valid && i_in_chan.ready;
    assign i_in_chan.ready  = !i_fifo_stat.full;
    assign i_cfg_chan.ready = 1'b1;

    assign len_sat = (i_in_chan.file_length > crf_pkg::LEN_W'(MAX_FILE_BYTES))
                   ? BR_W'(MAX_FILE_BYTES) : i_in_chan.file_length[BR_W-1:0];
    assign rem1  = r_rem - BR_W'(1);
    assign fill1 = {1'b0, r_fill} + 8'd1;
    assign sum1  = crf_pkg::add_carry(r_sum, i_in_chan.data_byte);
    assign sum2  = crf_pkg::add_carry(sum1, fill1);
    assign pad   = crf_pkg::FILL_LAST - fill1[crf_pkg::FILL_W-1:0];

    always_comb begin
        n_open    = r_open;
        n_rem     = r_rem;
        n_fill    = r_fill;
        n_sum     = r_sum;
        cmd       = '0;
        do_eof    = 1'b0;
        do_open   = 1'b0;
        open_full = 1'b0;

        if (accept) begin
            if (i_in_chan.opcode == crf_pkg::OP_BEGIN) begin
                // begin while open drops the old file with no end record
                n_open = 1'b1;
                n_rem  = len_sat;
                n_fill = '0;
                n_sum  = '0;
                cmd.mask[crf_pkg::STEP_LEAD] = (r_cfg.long_gap != '0);
                if (len_sat == '0) begin
                    do_eof = 1'b1;
                end else begin
                    do_open   = 1'b1;
                    open_full = crf_pkg::LEN_W'(len_sat) >=
                                crf_pkg::LEN_W'(crf_pkg::RECORD_BYTES);
                end
            end else if (r_open && r_rem != '0) begin
                cmd.mask[crf_pkg::STEP_DATA] = 1'b1;
                cmd.data = i_in_chan.data_byte;
                n_rem    = rem1;
                if (r_fill == crf_pkg::FILL_LAST) begin
                    cmd.mask[crf_pkg::STEP_CKSUM] = 1'b1;
                    cmd.cksum = sum1;
                    if (rem1 == '0) begin
                        do_eof = 1'b1;
                    end else begin
                        do_open   = 1'b1;
                        open_full = crf_pkg::LEN_W'(rem1) >=
                                    crf_pkg::LEN_W'(crf_pkg::RECORD_BYTES);
                    end
                end else if (rem1 == '0) begin
                    // short record: zero pad, length byte, checksum over both
                    cmd.mask[crf_pkg::STEP_PAD]   = (pad != '0);
                    cmd.mask[crf_pkg::STEP_LEN]   = 1'b1;
                    cmd.mask[crf_pkg::STEP_CKSUM] = 1'b1;
                    cmd.pad      = pad;
                    cmd.len_byte = fill1;
                    cmd.cksum    = sum2;
                    do_eof       = 1'b1;
                end else begin
                    n_sum  = sum1;
                    n_fill = fill1[crf_pkg::FILL_W-1:0];
                end
            end
        end

        if (do_eof) begin
            cmd.mask[crf_pkg::STEP_GAP]    = (r_cfg.short_gap != '0);
            cmd.mask[crf_pkg::STEP_SYNC]   = 1'b1;
            cmd.mask[crf_pkg::STEP_CTRL]   = 1'b1;
            cmd.mask[crf_pkg::STEP_ZERO]   = 1'b1;
            cmd.mask[crf_pkg::STEP_EOFSUM] = 1'b1;
            cmd.mask[crf_pkg::STEP_SIL]    = (r_cfg.silence != '0);
            cmd.ctrl = crf_pkg::CTRL_EOF;
            n_open   = 1'b0;
            n_rem    = '0;
            n_fill   = '0;
        end
        if (do_open) begin
            cmd.mask[crf_pkg::STEP_GAP]  = (r_cfg.short_gap != '0);
            cmd.mask[crf_pkg::STEP_SYNC] = 1'b1;
            cmd.mask[crf_pkg::STEP_CTRL] = 1'b1;
            cmd.ctrl = open_full ? crf_pkg::CTRL_FULL : crf_pkg::CTRL_PART;
            n_sum    = open_full ? crf_pkg::SEED_FULL : crf_pkg::SEED_PART;
            n_fill   = '0;
        end
    end

    assign o_push = accept && (cmd.mask != '0);
    assign o_cmd  = cmd;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_rem  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else begin
            r_open <= n_open;
            r_rem  <= n_rem;
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_gap <= crf_pkg::RST_SHORT_GAP;
            r_cfg.long_gap  <= crf_pkg::RST_LONG_GAP;
            r_cfg.silence   <= crf_pkg::RST_SILENCE;
        end else if (i_cfg_chan.valid && i_cfg_chan.ready) begin
            unique case (i_cfg_chan.index)
                crf_pkg::CFG_SHORT_GAP: r_cfg.short_gap <= i_cfg_chan.data;
                crf_pkg::CFG_LONG_GAP:  r_cfg.long_gap  <= i_cfg_chan.data;
                crf_pkg::CFG_SILENCE:   r_cfg.silence   <= i_cfg_chan.data;
                default: ;
            endcase
        end
    end

    a_empty_file_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_chan.opcode == crf_pkg::OP_BEGIN && i_in_chan.file_length == '0)
        |=> (!r_open && r_rem == '0))
        else $error("empty file left open");

    a_fill_tracks_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_rem == '0 && r_fill == '0))
        else $error("closed file holds residual state");

endmodule

/* hw/rtl/crf_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// crf_cmd_fifo: command queue between front end and output sequencer
// Small register queue; lets input and output sides stall independently.
// ----------------------------------------------------------------------------
module crf_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  crf_pkg::t_cmd        i_wr_data,
    input  logic                 i_pop,
    output crf_pkg::t_fifo_stat  o_stat,
    output crf_pkg::t_cmd        o_rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    crf_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign o_rd_data    = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_stat.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("command queue overflow");

    a_no_empty_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_wr_data.mask != '0))
        else $error("command with no output steps queued");

endmodule

/* hw/rtl/crf_back.sv */
// ----------------------------------------------------------------------------
// crf_back: output sequencer
// Walks the pending steps of the current command into a registered output
// stage, one result word per cycle while that stage can take one.
// ----------------------------------------------------------------------------
module crf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  crf_pkg::t_fifo_stat  i_fifo_stat,
    input  crf_pkg::t_cmd        i_cmd,
    input  crf_pkg::t_cfg        i_cfg,
    output logic                 o_pop,
    crf_out_if.source            o_out_chan
);

    crf_pkg::t_cmd                r_cmd;
    crf_pkg::t_step_mask          r_mask;
    logic                         r_out_valid;
    crf_pkg::t_kind               r_out_kind;
    logic [crf_pkg::BYTE_W-1:0]   r_out_char;
    logic [crf_pkg::REP_W-1:0]    r_out_rep;
    logic                         r_out_last;

    logic [crf_pkg::STEP_W-1:0]   sel;
    crf_pkg::t_step_mask          sel_bit;
    crf_pkg::t_step_mask          rest;
    logic                         can_emit;
    logic                         emit;
    logic                         pop;
    crf_pkg::t_kind               res_kind;
    logic [crf_pkg::BYTE_W-1:0]   res_char;
    logic [crf_pkg::REP_W-1:0]    res_rep;

    // lowest pending step goes next
    always_comb begin
        sel     = '0;
        sel_bit = '0;
        for (int k = crf_pkg::STEP_COUNT - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel     = crf_pkg::STEP_W'(k);
                sel_bit = crf_pkg::t_step_mask'(1) << k;
            end
        end
    end

    assign rest     = r_mask & ~sel_bit;
    assign can_emit = !r_out_valid || o_out_chan.ready;
    assign emit     = (r_mask != '0) && can_emit;
    assign pop      = i_fifo_stat.valid && ((r_mask == '0) || (emit && rest == '0));
    assign o_pop    = pop;

    always_comb begin
        res_kind = crf_pkg::KIND_CHAR;
        res_char = '0;
        res_rep  = crf_pkg::REP_ONE;
        unique case (sel)
            crf_pkg::STEP_LEAD: begin
                res_kind = crf_pkg::KIND_MARK;
                res_rep  = i_cfg.long_gap;
            end
            crf_pkg::STEP_DATA:   res_char = r_cmd.data;
            crf_pkg::STEP_PAD:    res_rep  = crf_pkg::REP_W'(r_cmd.pad);
            crf_pkg::STEP_LEN:    res_char = r_cmd.len_byte;
            crf_pkg::STEP_CKSUM:  res_char = r_cmd.cksum;
            crf_pkg::STEP_GAP: begin
                res_kind = crf_pkg::KIND_MARK;
                res_rep  = i_cfg.short_gap;
            end
            crf_pkg::STEP_SYNC: begin
                res_char = crf_pkg::SYNC_BYTE;
                res_rep  = crf_pkg::REP_SYNC;
            end
            crf_pkg::STEP_CTRL:   res_char = r_cmd.ctrl;
            crf_pkg::STEP_ZERO:   res_rep  = crf_pkg::REP_RECORD;
            crf_pkg::STEP_EOFSUM: res_char = crf_pkg::SUM_EOF;
            crf_pkg::STEP_SIL: begin
                res_kind = crf_pkg::KIND_SILENCE;
                res_rep  = i_cfg.silence;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_mask <= i_cmd.mask;
            end else if (emit) begin
                r_mask <= rest;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out_chan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out_kind <= res_kind;
            r_out_char <= res_char;
            r_out_rep  <= res_rep;
            r_out_last <= (rest == '0);
        end
    end

    assign o_out_chan.valid      = r_out_valid;
    assign o_out_chan.kind       = r_out_kind;
    assign o_out_chan.char_byte  = r_out_char;
    assign o_out_chan.repeat_res = r_out_rep;
    assign o_out_chan.last       = r_out_last;

    a_no_zero_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_rep != '0))
        else $error("zero-length run emitted");

    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> ($countones(r_mask) <= 1))
        else $error("next command loaded with steps still pending");

endmodule

/* hw/rtl/cassette_record_framer_top.sv */
// ----------------------------------------------------------------------------
// cassette_record_framer_top: cassette record framer
// Input channel i_in_chan takes begin-file words (opcode 0, file_length) and
// data-byte words (opcode 1, data_byte). Output channel o_out_chan gives
// character, mark-run and silence-run words with a repeat count; last marks
// the final word caused by one input word. i_cfg_chan writes the short gap,
// long gap and silence lengths (index 0, 1, 2), always ready; write only
// while the block is idle.
// Throughput: the output sequencer gives one result word per cycle while
// the output accepts; an input word causes one result word for a byte
// inside a record, up to ten at a record or file boundary. The command queue
// absorbs short bursts; input stalls only when the queue is full. The queue,
// step mask and output register lie between acceptance and the first word.
// A stalled output holds its word and the sequencer waits; the queue keeps
// filling until it is full, then the input stalls.
// Reset clears file state and queue and loads the default gap lengths.
// ----------------------------------------------------------------------------
module cassette_record_framer_top #(
    parameter int MAX_FILE_BYTES = 131072,
    parameter int CMD_DEPTH      = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crf_in_if.sink      i_in_chan,
    crf_cfg_if.sink     i_cfg_chan,
    crf_out_if.source   o_out_chan
);

    crf_pkg::t_fifo_stat fifo_stat;
    crf_pkg::t_cmd       wr_cmd;
    crf_pkg::t_cmd       rd_cmd;
    crf_pkg::t_cfg       cfg;
    logic                push;
    logic                pop;

    crf_front #(
        .MAX_FILE_BYTES (MAX_FILE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_chan   (i_in_chan),
        .i_cfg_chan  (i_cfg_chan),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_cmd       (wr_cmd),
        .o_cfg       (cfg)
    );

    crf_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_cmd),
        .i_pop     (pop),
        .o_stat    (fifo_stat),
        .o_rd_data (rd_cmd)
    );

    crf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_stat (fifo_stat),
        .i_cmd       (rd_cmd),
        .i_cfg       (cfg),
        .o_pop       (pop),
        .o_out_chan  (o_out_chan)
    );

endmodule

/* tb/sv/tb_cassette_record_framer_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cassette_record_framer_top: self-checking bench for the record framer
// Feeds begin-file and data-byte words through the input channel, predicts
// the leader, record, end-of-file and silence words in a local framer model,
// and checks every output word field by field. Gap and silence lengths are
// rewritten between phases, both channels idle at random, and one long
// output stall backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_cassette_record_framer_top;

    localparam int          MAX_FILE_BYTES = 131072;
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [crf_pkg::OPCODE_W-1:0] opcode;
        logic [crf_pkg::LEN_W-1:0]    file_length;
        logic [crf_pkg::BYTE_W-1:0]   data_byte;
    } t_tape_cmd;

    typedef struct {
        crf_pkg::t_kind             kind;
        logic [crf_pkg::BYTE_W-1:0] char_byte;
        logic [crf_pkg::REP_W-1:0]  repeat_res;
        logic                       last;
    } t_framed_word;

    logic i_clk;
    logic i_rst_n;

    crf_in_if  in_chan ();
    crf_cfg_if cfg_chan ();
    crf_out_if out_chan ();

    cassette_record_framer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_chan),
        .i_cfg_chan (cfg_chan),
        .o_out_chan (out_chan)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Commands waiting to go out, and words the framer owes us
    t_tape_cmd    tape_cmds [$];
    t_framed_word framed_words [$];

    // Local copy of the framer registers and file state
    logic [crf_pkg::REP_W-1:0]  short_gap;
    logic [crf_pkg::REP_W-1:0]  long_gap;
    logic [crf_pkg::REP_W-1:0]  silence_len;
    logic [crf_pkg::LEN_W-1:0]  bytes_left;
    logic [crf_pkg::BYTE_W-1:0] rec_count;
    logic [crf_pkg::BYTE_W-1:0] rec_fill;
    logic [crf_pkg::BYTE_W-1:0] rec_sum;
    logic                       file_open;

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned sink_hold_left;
    int unsigned cmds_queued;
    int unsigned cmds_sent;
    int unsigned words_checked;
    int unsigned reg_writes;
    int unsigned settings_used;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    bit          cmd_taken;
    t_framed_word got_ref;

    // ------------------------------------------------------------------
    // Framer model
    // ------------------------------------------------------------------
    function automatic logic [crf_pkg::BYTE_W-1:0] ones_sum(
        input logic [crf_pkg::BYTE_W-1:0] a,
        input logic [crf_pkg::BYTE_W-1:0] b);
        logic [crf_pkg::BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[crf_pkg::BYTE_W] ? s[crf_pkg::BYTE_W-1:0] + 8'd1 : s[crf_pkg::BYTE_W-1:0];
    endfunction

    function automatic void emit_word(input crf_pkg::t_kind k,
                                      input logic [crf_pkg::BYTE_W-1:0] c,
                                      input logic [crf_pkg::REP_W-1:0] r);
        t_framed_word w;
        w.kind       = k;
        w.char_byte  = c;
        w.repeat_res = r;
        w.last       = 1'b0;
        framed_words.push_back(w);
    endfunction

    // zero-length runs produce nothing
    function automatic void emit_run(input crf_pkg::t_kind k,
                                     input logic [crf_pkg::REP_W-1:0] r);
        if (r != '0) begin
            emit_word(k, '0, r);
        end
    endfunction

    function automatic void open_record();
        logic full;
        full = (bytes_left >= crf_pkg::LEN_W'(crf_pkg::RECORD_BYTES));
        emit_run(crf_pkg::KIND_MARK, short_gap);
        emit_word(crf_pkg::KIND_CHAR, crf_pkg::SYNC_BYTE, crf_pkg::REP_SYNC);
        emit_word(crf_pkg::KIND_CHAR, full ? crf_pkg::CTRL_FULL : crf_pkg::CTRL_PART,
                  crf_pkg::REP_ONE);
        rec_sum   = full ? crf_pkg::SEED_FULL : crf_pkg::SEED_PART;
        rec_fill  = '0;
        rec_count = rec_count + 8'd1;
    endfunction

    function automatic void close_file();
        emit_run(crf_pkg::KIND_MARK, short_gap);
        emit_word(crf_pkg::KIND_CHAR, crf_pkg::SYNC_BYTE, crf_pkg::REP_SYNC);
        emit_word(crf_pkg::KIND_CHAR, crf_pkg::CTRL_EOF, crf_pkg::REP_ONE);
        emit_word(crf_pkg::KIND_CHAR, '0, crf_pkg::REP_RECORD);
        emit_word(crf_pkg::KIND_CHAR, crf_pkg::SUM_EOF, crf_pkg::REP_ONE);
        emit_run(crf_pkg::KIND_SILENCE, silence_len);
        rec_count  = rec_count + 8'd1;
        file_open  = 1'b0;
        bytes_left = '0;
        rec_fill   = '0;
    endfunction

    function automatic void frame_cmd(input t_tape_cmd c);
        logic [crf_pkg::LEN_W-1:0]  len;
        logic [crf_pkg::BYTE_W-1:0] pad;
        int unsigned                n0;
        n0 = framed_words.size();
        if (c.opcode == crf_pkg::OP_BEGIN) begin
            len = (c.file_length > crf_pkg::LEN_W'(MAX_FILE_BYTES))
                ? crf_pkg::LEN_W'(MAX_FILE_BYTES) : c.file_length;
            bytes_left = len;
            rec_fill   = '0;
            rec_sum    = '0;
            file_open  = 1'b1;
            emit_run(crf_pkg::KIND_MARK, long_gap);
            if (len == '0) begin
                close_file();
            end else begin
                open_record();
            end
        end else if (file_open && bytes_left != '0) begin
            emit_word(crf_pkg::KIND_CHAR, c.data_byte, crf_pkg::REP_ONE);
            rec_sum    = ones_sum(rec_sum, c.data_byte);
            rec_fill   = rec_fill + 8'd1;
            bytes_left = bytes_left - 1'b1;
            if (rec_fill >= 8'(crf_pkg::RECORD_BYTES)) begin
                emit_word(crf_pkg::KIND_CHAR, rec_sum, crf_pkg::REP_ONE);
                if (bytes_left == '0) begin
                    close_file();
                end else begin
                    open_record();
                end
            end else if (bytes_left == '0) begin
                // short record: zero pad to 127, then the length byte
                pad = 8'd127 - rec_fill;
                if (pad != '0) begin
                    emit_word(crf_pkg::KIND_CHAR, '0, crf_pkg::REP_W'(pad));
                end
                emit_word(crf_pkg::KIND_CHAR, rec_fill, crf_pkg::REP_ONE);
                rec_sum = ones_sum(rec_sum, rec_fill);
                emit_word(crf_pkg::KIND_CHAR, rec_sum, crf_pkg::REP_ONE);
                close_file();
            end
        end
        if (framed_words.size() > n0) begin
            framed_words[framed_words.size()-1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && in_chan.valid && in_chan.ready) begin
            frame_cmd(tape_cmds.pop_front());
            cmds_sent++;
            cmd_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!in_chan.valid || cmd_taken) begin
            cmd_taken = 1'b0;
            if (tape_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                in_chan.valid       <= 1'b1;
                in_chan.opcode      <= tape_cmds[0].opcode;
                in_chan.file_length <= tape_cmds[0].file_length;
                in_chan.data_byte   <= tape_cmds[0].data_byte;
            end else begin
                in_chan.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch at word %0d, %s: expected %0h, got %0h",
                 words_checked, what, want, got);
        mismatch_count++;
    endtask

    always @(negedge i_clk) begin
        if (sink_hold_left != 0) begin
            sink_hold_left  = sink_hold_left - 1;
            out_chan.ready <= 1'b0;
        end else begin
            out_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_chan.valid && out_chan.ready) begin
            if (framed_words.size() == 0) begin
                report_mismatch("unexpected word, kind", 0, out_chan.kind);
            end else begin
                got_ref = framed_words.pop_front();
                if (out_chan.kind !== got_ref.kind)
                    report_mismatch("kind", got_ref.kind, out_chan.kind);
                if (out_chan.char_byte !== got_ref.char_byte)
                    report_mismatch("char_byte", got_ref.char_byte, out_chan.char_byte);
                if (out_chan.repeat_res !== got_ref.repeat_res)
                    report_mismatch("repeat_res", got_ref.repeat_res, out_chan.repeat_res);
                if (out_chan.last !== got_ref.last)
                    report_mismatch("last", got_ref.last, out_chan.last);
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any handshake
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_chan.valid && in_chan.ready) ||
            (out_chan.valid && out_chan.ready) || (cfg_chan.valid && cfg_chan.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d words still owed",
                     quiet_cycles, framed_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void queue_cmd(input logic [crf_pkg::OPCODE_W-1:0] op,
                                      input logic [crf_pkg::LEN_W-1:0] len,
                                      input logic [crf_pkg::BYTE_W-1:0] b);
        t_tape_cmd c;
        c.opcode      = op;
        c.file_length = len;
        c.data_byte   = b;
        tape_cmds.push_back(c);
        cmds_queued++;
    endfunction

    function automatic void queue_byte(input logic [crf_pkg::BYTE_W-1:0] b);
        queue_cmd(crf_pkg::OP_DATA, crf_pkg::LEN_W'($urandom_range(262143)), b);
    endfunction

    // one file; sometimes cut short (next begin abandons it) or trailed by strays
    function automatic void queue_file(input int unsigned nbytes);
        int unsigned cut;
        queue_cmd(crf_pkg::OP_BEGIN, crf_pkg::LEN_W'(nbytes),
                  crf_pkg::BYTE_W'($urandom_range(255)));
        cut = nbytes;
        if (nbytes > 1 && $urandom_range(9) == 0) begin
            cut = $urandom_range(nbytes - 1);
        end
        for (int unsigned k = 0; k < cut; k++) begin
            queue_byte(crf_pkg::BYTE_W'($urandom_range(255)));
        end
        if (cut == nbytes && $urandom_range(4) == 0) begin
            for (int k = $urandom_range(1, 2); k > 0; k--) begin
                queue_byte(crf_pkg::BYTE_W'($urandom_range(255)));
            end
        end
    endfunction

    // oversized length saturates; up to three bytes, then left open
    function automatic void queue_oversized();
        queue_cmd(crf_pkg::OP_BEGIN,
                  crf_pkg::LEN_W'($urandom_range(262143, MAX_FILE_BYTES + 1)),
                  crf_pkg::BYTE_W'($urandom_range(255)));
        for (int k = $urandom_range(3); k > 0; k--) begin
            queue_byte(crf_pkg::BYTE_W'($urandom_range(255)));
        end
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return 0;
        if (r < 85) return $urandom_range(20, 1);
        return $urandom_range(60, 21);
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk); while (tape_cmds.size() != 0 || framed_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [crf_pkg::REP_W-1:0] gap_s,
                                  input logic [crf_pkg::REP_W-1:0] gap_l,
                                  input logic [crf_pkg::REP_W-1:0] sil);
        logic [crf_pkg::REP_W-1:0]     vals [3];
        logic [crf_pkg::CFG_IDX_W-1:0] idx [3];
        vals = '{gap_s, gap_l, sil};
        idx  = '{crf_pkg::CFG_SHORT_GAP, crf_pkg::CFG_LONG_GAP, crf_pkg::CFG_SILENCE};
        for (int k = 0; k < 3; k++) begin
            @(negedge i_clk);
            cfg_chan.valid <= 1'b1;
            cfg_chan.index <= idx[k];
            cfg_chan.data  <= vals[k];
            do @(posedge i_clk); while (cfg_chan.ready !== 1'b1);
            case (idx[k])
                crf_pkg::CFG_SHORT_GAP: short_gap   = vals[k];
                crf_pkg::CFG_LONG_GAP:  long_gap    = vals[k];
                crf_pkg::CFG_SILENCE:   silence_len = vals[k];
                default: ;
            endcase
            reg_writes++;
        end
        @(negedge i_clk);
        cfg_chan.valid <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    initial begin : stimulus
        int unsigned phase_start;
        int unsigned quota;

        i_rst_n              = 1'b0;
        in_chan.valid        = 1'b0;
        in_chan.opcode       = crf_pkg::OP_BEGIN;
        in_chan.file_length  = '0;
        in_chan.data_byte    = '0;
        cfg_chan.valid       = 1'b0;
        cfg_chan.index       = crf_pkg::CFG_SHORT_GAP;
        cfg_chan.data        = '0;
        out_chan.ready       = 1'b0;
        short_gap            = crf_pkg::RST_SHORT_GAP;
        long_gap             = crf_pkg::RST_LONG_GAP;
        silence_len          = crf_pkg::RST_SILENCE;
        bytes_left           = '0;
        rec_count            = '0;
        rec_fill             = '0;
        rec_sum              = '0;
        file_open            = 1'b0;
        src_idle_pct         = 13;
        sink_idle_pct        = 52;
        sink_hold_left       = 0;
        cmds_queued          = 0;
        cmds_sent            = 0;
        words_checked        = 0;
        reg_writes           = 0;
        settings_used        = 1;
        mismatch_count       = 0;
        quiet_cycles         = 0;
        cmd_taken            = 1'b0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset lengths
        queue_cmd(crf_pkg::OP_DATA, '0, 8'hA5);          // byte with no file open
        queue_cmd(crf_pkg::OP_BEGIN, '0, 8'hFF);         // empty file
        queue_cmd(crf_pkg::OP_BEGIN, '1, 8'h00);         // oversized, saturates
        queue_cmd(crf_pkg::OP_DATA, '1, 8'h00);
        queue_cmd(crf_pkg::OP_DATA, '0, 8'hFF);
        queue_cmd(crf_pkg::OP_DATA, '0, 8'h80);
        queue_cmd(crf_pkg::OP_BEGIN, 18'd1, 8'h00);      // abandons the open file
        queue_cmd(crf_pkg::OP_DATA, '0, 8'hFF);          // one-byte record
        queue_cmd(crf_pkg::OP_DATA, '0, 8'h5A);          // past the length
        queue_cmd(crf_pkg::OP_BEGIN, 18'd2, 8'h00);
        queue_cmd(crf_pkg::OP_DATA, '0, 8'hFF);          // checksum carry wraps
        queue_cmd(crf_pkg::OP_DATA, '0, 8'hFF);
        queue_cmd(crf_pkg::OP_BEGIN, 18'd3, 8'h00);
        queue_cmd(crf_pkg::OP_DATA, '0, 8'h01);
        queue_cmd(crf_pkg::OP_DATA, '0, 8'h02);
        queue_cmd(crf_pkg::OP_DATA, '0, 8'h7F);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            quota = 12;
            case (ph)
                0: begin
                    src_idle_pct  = 13;
                    sink_idle_pct = 52;
                    write_settings('0, '0, '0);
                end
                1: begin
                    write_settings('1, '1, '1);
                    // full record then a 127-byte record with no padding;
                    // output held off while the input keeps offering
                    queue_file(255);
                    sink_hold_left = HOLD_CYCLES;
                    quota = 0;
                end
                2: begin
                    src_idle_pct  = 52;
                    sink_idle_pct = 13;
                    write_settings(crf_pkg::REP_W'($urandom_range(16383, 1)),
                                   crf_pkg::REP_W'($urandom_range(16383, 1)),
                                   crf_pkg::REP_W'($urandom_range(16383, 1)));
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    write_settings(crf_pkg::REP_W'(1), '1, crf_pkg::REP_W'(1));
                end
            endcase
            phase_start = cmds_queued;
            while (cmds_queued - phase_start < quota) begin
                if ($urandom_range(19) == 0) begin
                    queue_oversized();
                end else begin
                    queue_file(pick_length());
                end
                // sender waits for the output to catch up
                if ($urandom_range(5) == 0) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        $display("sent %0d commands, checked %0d output words", cmds_sent, words_checked);
        $display("%0d register writes over %0d gap/silence settings, one long output stall",
                 reg_writes, settings_used);
        if (mismatch_count == 0 && framed_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
